@@ sv/tpg_pkg.sv @@
// ----------------------------------------------------------------------------
// tpg_pkg: shared types and constants of the text and 2bpp pixel generator
// Transaction payloads, memory request bundle, memory map offsets and the
// fixed graphics colors.
// ----------------------------------------------------------------------------
package tpg_pkg;

	// field widths
	localparam int ADDR_W  = 17;
	localparam int IDX_W   = 15;   // covers video memory depths up to 32768 bytes
	localparam int COLOR_W = 24;

	// commands
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
	localparam logic [1:0] REG_CURSOR_COL   = 2'd1;
	localparam logic [1:0] REG_CURSOR_ROW   = 2'd2;

	// display modes
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_GFX  = 2'd2;

	// emulated address window held in video memory
	localparam logic [ADDR_W-1:0] WIN_BASE = 17'h0C000;
	localparam logic [ADDR_W-1:0] WIN_LAST = 17'h10FFF;

	// memory map as offsets from the window base
	localparam logic [IDX_W-1:0] TEXT_OFS = 15'h3000;  // 0xF000
	localparam logic [IDX_W-1:0] FONT_OFS = 15'h4000;  // 0x10000
	localparam logic [IDX_W-1:0] PAL_OFS  = 15'h3FA0;  // 0xFFA0
	localparam logic [11:0]      ROW_BYTES = 12'd160;

	// text cursor occupies the last font rows
	localparam logic [3:0] CURSOR_FIRST_ROW = 4'd14;

	// active areas
	localparam logic [10:0] TEXT_W = 11'd1280;
	localparam logic [9:0]  TEXT_H = 10'd800;
	localparam logic [10:0] GFX_W  = 11'd768;
	localparam logic [9:0]  GFX_H  = 10'd720;

	// divide by three as multiply by reciprocal, exact for values below 768
	localparam logic [9:0] RECIP3       = 10'd683;
	localparam int         RECIP3_SHIFT = 11;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] address;
		logic [7:0]        data;
		logic [10:0]       pixel_x;
		logic [9:0]        pixel_y;
		logic              blink_phase;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
	} rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [6:0] value;
	} cfg_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [7:0]       wdata;
		logic             re_a;
		logic [IDX_W-1:0] raddr_a;
		logic             re_b;
		logic [IDX_W-1:0] raddr_b;
	} mem_req_t;

	// fixed four-color graphics palette
	function automatic logic [COLOR_W-1:0] gfx_color(input logic [1:0] code);
		logic [COLOR_W-1:0] c;
		case (code)
			2'd0:    c = 24'h000000;
			2'd1:    c = 24'hC00000;
			2'd2:    c = 24'h00C000;
			default: c = 24'h0060FF;
		endcase
		return c;
	endfunction

endpackage

@@ sv/tpg_chan_if.sv @@
// ----------------------------------------------------------------------------
// tpg_chan_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface tpg_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/tpg_vmem.sv @@
// ----------------------------------------------------------------------------
// tpg_vmem: video memory
// Byte-wide synchronous memory, one write port and two read ports with
// registered read data; read data holds while its port is not enabled.
// ----------------------------------------------------------------------------
module tpg_vmem import tpg_pkg::*; #(
	parameter int DEPTH = 20480
) (
	input  logic       clk,
	input  mem_req_t   mem_req,
	output logic [7:0] rdata_a,
	output logic [7:0] rdata_b
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_a_q;
	logic [7:0] rdata_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (mem_req.we)
			mem[mem_req.waddr] <= mem_req.wdata;
	end

	// read ports
	always_ff @(posedge clk) begin
		if (mem_req.re_a)
			rdata_a_q <= mem[mem_req.raddr_a];
		if (mem_req.re_b)
			rdata_b_q <= mem[mem_req.raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

@@ sv/tpg_seq.sv @@
// ----------------------------------------------------------------------------
// tpg_seq: pixel sequencer
// Holds the configuration registers, steps each render transaction through
// its dependent video memory reads and forms the pixel color.
// ----------------------------------------------------------------------------
module tpg_seq import tpg_pkg::*; #(
	parameter int SCREEN_WIDTH       = 1280,
	parameter int SCREEN_HEIGHT      = 800,
	parameter int VIDEO_MEMORY_BYTES = 20480
) (
	input  logic      clk,
	input  logic      arst_n,
	tpg_chan_if.sink   req,
	tpg_chan_if.source rsp,
	tpg_chan_if.sink   cfg,
	output mem_req_t  mem_req,
	input  logic [7:0] rdata_a,
	input  logic [7:0] rdata_b
);

	typedef enum logic [1:0] {S_IDLE, S_FONT, S_PAL, S_COLOR} state_t;
	typedef enum logic [1:0] {K_BLACK, K_TEXT, K_GFX} kind_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [2:0]         dx_q;
	logic [3:0]         dy_q;
	logic               cur_q;
	logic [1:0]         sel_q;
	logic               rsp_valid_q;
	logic [COLOR_W-1:0] color_q;

	logic [1:0] mode_q;
	logic [6:0] cursor_col_q;
	logic [4:0] cursor_row_q;

	req_t               p;
	logic               load_ok;
	logic               acc;
	logic               in_window;
	logic               on_screen;
	logic [6:0]         col;
	logic [4:0]         row;
	logic [3:0]         dy;
	logic [11:0]        row_ofs;
	logic [IDX_W-1:0]   cell_idx;
	logic [19:0]        prod_x;
	logic [19:0]        prod_y;
	logic [7:0]         mx;
	logic [7:0]         my;
	logic [IDX_W-1:0]   gfx_idx;
	kind_t              kind_d;
	logic               cur_d;
	logic               font_bit;
	logic [3:0]         pal_idx;
	logic [COLOR_W-1:0] color_d;

	assign p = req.payload;

	// handshakes
	assign load_ok   = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) || (state_q == S_COLOR && load_ok);
	assign acc       = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload.pixel_color = color_q;

	// write window check
	always_comb begin
		in_window = (p.address >= WIN_BASE) && (p.address <= WIN_LAST) &&
			((p.address - WIN_BASE) < ADDR_W'(VIDEO_MEMORY_BYTES));
	end

	// pixel decode for a new render transaction
	always_comb begin
		on_screen = (12'({1'b0, p.pixel_x}) < 12'(SCREEN_WIDTH)) &&
			(12'({2'b0, p.pixel_y}) < 12'(SCREEN_HEIGHT));
		col      = p.pixel_x[10:4];
		row      = p.pixel_y[9:5];
		dy       = p.pixel_y[4:1];
		row_ofs  = 12'(row) * ROW_BYTES;
		cell_idx = TEXT_OFS + IDX_W'(row_ofs) + IDX_W'({col, 1'b0});
		prod_x   = 20'(p.pixel_x[9:0]) * 20'(RECIP3);
		prod_y   = 20'(p.pixel_y) * 20'(RECIP3);
		mx       = prod_x[RECIP3_SHIFT +: 8];
		my       = prod_y[RECIP3_SHIFT +: 8];
		gfx_idx  = IDX_W'({my, mx[7:2]});
		cur_d    = p.blink_phase && (col == cursor_col_q) && (row == cursor_row_q) &&
			(dy >= CURSOR_FIRST_ROW);
		kind_d = K_BLACK;
		if (on_screen) begin
			if (mode_q == MODE_TEXT && p.pixel_x < TEXT_W && p.pixel_y < TEXT_H)
				kind_d = K_TEXT;
			else if (mode_q == MODE_GFX && p.pixel_x < GFX_W && p.pixel_y < GFX_H)
				kind_d = K_GFX;
		end
	end

	// font bit and palette index from the font byte and held attribute
	always_comb begin
		font_bit = rdata_a[3'd7 - dx_q];
		pal_idx  = (font_bit ^ cur_q) ? rdata_b[3:0] : rdata_b[7:4];
	end

	// memory requests
	always_comb begin
		mem_req         = '0;
		mem_req.waddr   = IDX_W'(p.address - WIN_BASE);
		mem_req.wdata   = p.data;
		mem_req.we      = acc && p.command == CMD_WRITE && in_window;
		mem_req.raddr_a = cell_idx;
		mem_req.raddr_b = cell_idx + IDX_W'(1);
		unique case (state_q)
			S_FONT: begin
				mem_req.re_a    = 1'b1;
				mem_req.raddr_a = FONT_OFS + IDX_W'({rdata_a, dy_q});
			end
			S_PAL: begin
				mem_req.re_a    = 1'b1;
				mem_req.re_b    = 1'b1;
				mem_req.raddr_a = PAL_OFS + IDX_W'({pal_idx, 1'b0});
				mem_req.raddr_b = PAL_OFS + IDX_W'({pal_idx, 1'b1});
			end
			default: begin
				if (acc && p.command == CMD_RENDER) begin
					if (kind_d == K_TEXT) begin
						mem_req.re_a = 1'b1;
						mem_req.re_b = 1'b1;
					end else if (kind_d == K_GFX) begin
						mem_req.re_a    = 1'b1;
						mem_req.raddr_a = gfx_idx;
					end
				end
			end
		endcase
	end

	// final color
	always_comb begin
		color_d = '0;
		case (kind_q)
			K_TEXT: color_d = {rdata_b[3:0], 4'h0, rdata_a[7:4], 4'h0, rdata_a[3:0], 4'h0};
			K_GFX: begin
				case (sel_q)
					2'd0:    color_d = gfx_color(rdata_a[7:6]);
					2'd1:    color_d = gfx_color(rdata_a[5:4]);
					2'd2:    color_d = gfx_color(rdata_a[3:2]);
					default: color_d = gfx_color(rdata_a[1:0]);
				endcase
			end
			default: color_d = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_TEXT;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				REG_DISPLAY_MODE: mode_q       <= cfg.payload.value[1:0];
				REG_CURSOR_COL:   cursor_col_q <= cfg.payload.value;
				REG_CURSOR_ROW:   cursor_row_q <= cfg.payload.value[4:0];
				default: ;
			endcase
		end
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_BLACK;
			dx_q        <= '0;
			dy_q        <= '0;
			cur_q       <= 1'b0;
			sel_q       <= '0;
			rsp_valid_q <= 1'b0;
			color_q     <= '0;
		end else begin
			// a new render transaction starts its read sequence
			if (acc && p.command == CMD_RENDER) begin
				kind_q  <= kind_d;
				dx_q    <= p.pixel_x[3:1];
				dy_q    <= dy;
				cur_q   <= cur_d;
				sel_q   <= mx[1:0];
				state_q <= (kind_d == K_TEXT) ? S_FONT : S_COLOR;
			end else begin
				unique case (state_q)
					S_FONT:  state_q <= S_PAL;
					S_PAL:   state_q <= S_COLOR;
					S_COLOR: begin
						if (load_ok)
							state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
			// result register
			if (state_q == S_COLOR && load_ok) begin
				rsp_valid_q <= 1'b1;
				color_q     <= color_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// never read and write the memory in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !(mem_req.re_a || mem_req.re_b))
		else $error("memory write overlaps a read");

	// font read is always followed by the palette read
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FONT |=> state_q == S_PAL)
		else $error("font read not followed by palette read");

	// a new result only comes out of the color state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_COLOR))
		else $error("result loaded outside the color state");

	// a result waiting with no room blocks the sequencer in the color state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COLOR && rsp_valid_q && !rsp.ready) |=> state_q == S_COLOR)
		else $error("sequencer left the color state with the result register full");

endmodule

@@ sv/text_and_2bpp_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// text_and_2bpp_pixel_generator: video memory and pixel generator
// Stores writes into the video window and renders text or 2bpp pixels.
// ----------------------------------------------------------------------------
// A write transaction stores a byte at emulated address 0xC000..0x10FFF and
// gives no result. A render transaction gives one RGB 8:8:8 color. A text
// pixel needs three dependent reads of the two-port video memory: character
// and attribute, then font byte, then both palette bytes. A graphics pixel
// needs no font or palette read and a black pixel no read at all. The
// next transaction is taken in the cycle the result is loaded, and a result
// waiting on the output does not hold up input unless a second result is ready.
// Video memory content is undefined after reset until written; there is no
// clearing pass. Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
module text_and_2bpp_pixel_generator import tpg_pkg::*; #(
	parameter int SCREEN_WIDTH       = 1280,
	parameter int SCREEN_HEIGHT      = 800,
	parameter int VIDEO_MEMORY_BYTES = 20480
) (
	input  logic       clk,
	input  logic       arst_n,
	tpg_chan_if.sink   req,
	tpg_chan_if.source rsp,
	tpg_chan_if.sink   cfg
);

	mem_req_t   mem_req;
	logic [7:0] rdata_a;
	logic [7:0] rdata_b;

	// sequencer and configuration
	tpg_seq #(
		.SCREEN_WIDTH       (SCREEN_WIDTH),
		.SCREEN_HEIGHT      (SCREEN_HEIGHT),
		.VIDEO_MEMORY_BYTES (VIDEO_MEMORY_BYTES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.mem_req (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// video memory
	tpg_vmem #(
		.DEPTH (VIDEO_MEMORY_BYTES)
	) u_vmem (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule
